// File: rtl/sgdmf_pkg.sv
// Shared types, codes and helpers for the SGD matrix factorization engine.
package sgdmf_pkg;

  localparam logic [2:0] OP_WR_ROW = 3'd0;
  localparam logic [2:0] OP_WR_COL = 3'd1;
  localparam logic [2:0] OP_TRAIN  = 3'd2;
  localparam logic [2:0] OP_EVAL   = 3'd3;
  localparam logic [2:0] OP_RD_ROW = 3'd4;
  localparam logic [2:0] OP_RD_COL = 3'd5;

  localparam logic CFG_LR   = 1'b0;
  localparam logic CFG_RANK = 1'b1;

  localparam logic [15:0] LR_RESET   = 16'd655;
  localparam logic [4:0]  RANK_RESET = 5'd16;

  localparam logic signed [55:0] Q_MAX = 56'sd2147483647;
  localparam logic signed [55:0] Q_MIN = -56'sd2147483648;

  typedef enum logic [2:0] {
    K_NOP, K_WR_ROW, K_WR_COL, K_RD_ROW, K_RD_COL, K_TRAIN, K_EVAL
  } kind_t;

  typedef enum logic [1:0] {M_DOT, M_STEP, M_ROW, M_COL} mode_t;

  typedef enum logic [1:0] {R_ZERO, R_ROW, R_COL, R_ERR} res_sel_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_DOT_ISSUE, S_DOT_DRAIN, S_ERR, S_STEP_ISSUE,
    S_STEP_DRAIN, S_ROW_ISSUE, S_ROW_DRAIN, S_COL_ISSUE, S_COL_DRAIN, S_FINISH
  } state_t;

  typedef struct packed {
    logic     in_take;
    logic     wr_en;
    logic     rd_en;
    logic     sel_item_slot;
    logic     issue;
    mode_t    mode;
    logic     acc_clr;
    logic     err_load;
    logic     out_load;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  pipe_busy;
    logic  out_free;
    logic  rank_zero;
  } status_t;

  // Saturate a wide signed value to Q16.16; the top bit flags a clip.
  function automatic logic [32:0] clip_q(input logic signed [55:0] x);
    if (x > Q_MAX) begin
      return {1'b1, 32'h7FFF_FFFF};
    end else if (x < Q_MIN) begin
      return {1'b1, 32'h8000_0000};
    end else begin
      return {1'b0, x[31:0]};
    end
  endfunction

endpackage

// File: rtl/sgdmf_ctrl.sv
// Controller state machine that sequences reads, passes and result beats.
module sgdmf_ctrl #(
  parameter int RANK = 16,
  parameter int SW   = (RANK > 1) ? $clog2(RANK) : 1,
  parameter int NW   = $clog2(RANK + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sgdmf_pkg::status_t stat,
  input  logic [NW-1:0]      rank_n,
  output sgdmf_pkg::cmd_t    cmd,
  output logic [SW-1:0]      slot
);

  sgdmf_pkg::state_t state_r, state_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic last;

  assign last = ((cnt_r + NW'(1)) == rank_n);
  assign slot = cnt_r[SW-1:0];
  assign in_stall = (state_r != sgdmf_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sgdmf_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      sgdmf_pkg::S_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) state_nxt = sgdmf_pkg::S_DECODE;
      end
      sgdmf_pkg::S_DECODE: begin
        case (stat.kind)
          sgdmf_pkg::K_TRAIN, sgdmf_pkg::K_EVAL: begin
            state_nxt = stat.rank_zero ? sgdmf_pkg::S_ERR : sgdmf_pkg::S_DOT_ISSUE;
          end
          default: state_nxt = sgdmf_pkg::S_FINISH;
        endcase
      end
      sgdmf_pkg::S_DOT_ISSUE: begin
        cnt_nxt = last ? '0 : cnt_r + NW'(1);
        if (last) state_nxt = sgdmf_pkg::S_DOT_DRAIN;
      end
      sgdmf_pkg::S_DOT_DRAIN: begin
        if (!stat.pipe_busy) state_nxt = sgdmf_pkg::S_ERR;
      end
      sgdmf_pkg::S_ERR: begin
        state_nxt = (stat.kind == sgdmf_pkg::K_TRAIN) ? sgdmf_pkg::S_STEP_ISSUE
                                                     : sgdmf_pkg::S_FINISH;
      end
      sgdmf_pkg::S_STEP_ISSUE: state_nxt = sgdmf_pkg::S_STEP_DRAIN;
      sgdmf_pkg::S_STEP_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = stat.rank_zero ? sgdmf_pkg::S_FINISH : sgdmf_pkg::S_ROW_ISSUE;
        end
      end
      sgdmf_pkg::S_ROW_ISSUE: begin
        cnt_nxt = last ? '0 : cnt_r + NW'(1);
        if (last) state_nxt = sgdmf_pkg::S_ROW_DRAIN;
      end
      sgdmf_pkg::S_ROW_DRAIN: begin
        if (!stat.pipe_busy) state_nxt = sgdmf_pkg::S_COL_ISSUE;
      end
      sgdmf_pkg::S_COL_ISSUE: begin
        cnt_nxt = last ? '0 : cnt_r + NW'(1);
        if (last) state_nxt = sgdmf_pkg::S_COL_DRAIN;
      end
      sgdmf_pkg::S_COL_DRAIN: begin
        if (!stat.pipe_busy) state_nxt = sgdmf_pkg::S_FINISH;
      end
      sgdmf_pkg::S_FINISH: begin
        if (stat.out_free) state_nxt = sgdmf_pkg::S_IDLE;
      end
      default: state_nxt = sgdmf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mode = sgdmf_pkg::M_DOT;
    cmd.res_sel = sgdmf_pkg::R_ZERO;
    case (state_r)
      sgdmf_pkg::S_IDLE: cmd.in_take = in_valid;
      sgdmf_pkg::S_DECODE: begin
        case (stat.kind)
          sgdmf_pkg::K_WR_ROW, sgdmf_pkg::K_WR_COL: begin
            cmd.wr_en = 1'b1;
            cmd.sel_item_slot = 1'b1;
          end
          sgdmf_pkg::K_RD_ROW, sgdmf_pkg::K_RD_COL: begin
            cmd.rd_en = 1'b1;
            cmd.sel_item_slot = 1'b1;
          end
          sgdmf_pkg::K_TRAIN, sgdmf_pkg::K_EVAL: cmd.acc_clr = 1'b1;
          default: cmd.acc_clr = 1'b0;
        endcase
      end
      sgdmf_pkg::S_DOT_ISSUE: begin
        cmd.issue = 1'b1;
        cmd.rd_en = 1'b1;
      end
      sgdmf_pkg::S_DOT_DRAIN: cmd.mode = sgdmf_pkg::M_DOT;
      sgdmf_pkg::S_ERR: cmd.err_load = 1'b1;
      sgdmf_pkg::S_STEP_ISSUE: begin
        cmd.issue = 1'b1;
        cmd.mode = sgdmf_pkg::M_STEP;
      end
      sgdmf_pkg::S_STEP_DRAIN: cmd.mode = sgdmf_pkg::M_STEP;
      sgdmf_pkg::S_ROW_ISSUE: begin
        cmd.issue = 1'b1;
        cmd.rd_en = 1'b1;
        cmd.mode = sgdmf_pkg::M_ROW;
      end
      sgdmf_pkg::S_ROW_DRAIN: cmd.mode = sgdmf_pkg::M_ROW;
      sgdmf_pkg::S_COL_ISSUE: begin
        cmd.issue = 1'b1;
        cmd.rd_en = 1'b1;
        cmd.mode = sgdmf_pkg::M_COL;
      end
      sgdmf_pkg::S_COL_DRAIN: cmd.mode = sgdmf_pkg::M_COL;
      sgdmf_pkg::S_FINISH: begin
        cmd.out_load = stat.out_free;
        case (stat.kind)
          sgdmf_pkg::K_RD_ROW: cmd.res_sel = sgdmf_pkg::R_ROW;
          sgdmf_pkg::K_RD_COL: cmd.res_sel = sgdmf_pkg::R_COL;
          sgdmf_pkg::K_TRAIN, sgdmf_pkg::K_EVAL: cmd.res_sel = sgdmf_pkg::R_ERR;
          default: cmd.res_sel = sgdmf_pkg::R_ZERO;
        endcase
      end
      default: cmd.in_take = 1'b0;
    endcase
  end

endmodule

// File: rtl/sgdmf_dpath.sv
// Datapath: factor memories, shared multiplier pipeline, accumulator and result register.
module sgdmf_dpath #(
  parameter int ROWS = 64,
  parameter int COLS = 64,
  parameter int RANK = 16,
  parameter int SW   = (RANK > 1) ? $clog2(RANK) : 1,
  parameter int NW   = $clog2(RANK + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         in_opcode,
  input  logic [5:0]         in_row_index,
  input  logic [5:0]         in_col_index,
  input  logic [3:0]         in_rank_slot,
  input  logic [31:0]        in_value,
  input  logic               cfg_valid,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_result_value,
  output logic               out_saturated,
  input  sgdmf_pkg::cmd_t    cmd,
  input  logic [SW-1:0]      slot,
  output sgdmf_pkg::status_t stat,
  output logic [NW-1:0]      rank_n
);

  localparam int RAW = (ROWS * RANK > 1) ? $clog2(ROWS * RANK) : 1;
  localparam int CAW = (COLS * RANK > 1) ? $clog2(COLS * RANK) : 1;

  logic [31:0] row_mem [ROWS*RANK];
  logic [31:0] col_mem [COLS*RANK];

  logic [15:0] lr_r;
  logic [4:0]  rank_r;
  logic [2:0]  op_r;
  logic [5:0]  row_r, col_r;
  logic [3:0]  slot_item_r;
  logic [31:0] val_r;
  logic [RAW-1:0] row_base_r;
  logic [CAW-1:0] col_base_r;

  logic [31:0] rd_row_r, rd_col_r, old2_r, err_r;
  logic [SW-1:0] slot1_r, slot2_r;
  logic v1_r, v2_r;
  logic signed [65:0] prod_r;
  logic signed [32:0] step_r;
  logic signed [55:0] acc_r;
  logic sat_r;
  logic out_valid_r, out_sat_r;
  logic [31:0] out_res_r;

  logic [SW-1:0] rd_slot;
  logic [RAW-1:0] row_ra, row_wa;
  logic [CAW-1:0] col_ra, col_wa;
  logic signed [32:0] mul_a, mul_b;
  logic signed [55:0] err_diff, upd_sum;
  logic [32:0] err_clip, upd_clip;
  logic row_ok, col_ok, slot_ok;
  logic row_we, col_we;
  logic [31:0] wdata;
  sgdmf_pkg::kind_t kind;

  assign row_ok  = int'(row_r) < ROWS;
  assign col_ok  = int'(col_r) < COLS;
  assign slot_ok = int'(slot_item_r) < RANK;

  always_comb begin
    case (op_r)
      sgdmf_pkg::OP_WR_ROW: kind = (row_ok && slot_ok) ? sgdmf_pkg::K_WR_ROW : sgdmf_pkg::K_NOP;
      sgdmf_pkg::OP_WR_COL: kind = (col_ok && slot_ok) ? sgdmf_pkg::K_WR_COL : sgdmf_pkg::K_NOP;
      sgdmf_pkg::OP_RD_ROW: kind = (row_ok && slot_ok) ? sgdmf_pkg::K_RD_ROW : sgdmf_pkg::K_NOP;
      sgdmf_pkg::OP_RD_COL: kind = (col_ok && slot_ok) ? sgdmf_pkg::K_RD_COL : sgdmf_pkg::K_NOP;
      sgdmf_pkg::OP_TRAIN:  kind = (row_ok && col_ok) ? sgdmf_pkg::K_TRAIN : sgdmf_pkg::K_NOP;
      sgdmf_pkg::OP_EVAL:   kind = (row_ok && col_ok) ? sgdmf_pkg::K_EVAL : sgdmf_pkg::K_NOP;
      default:              kind = sgdmf_pkg::K_NOP;
    endcase
  end

  assign rank_n = (int'(rank_r) > RANK) ? NW'(RANK) : NW'(rank_r);

  assign stat.kind      = kind;
  assign stat.pipe_busy = v1_r | v2_r;
  assign stat.out_free  = !out_valid_r || !out_stall;
  assign stat.rank_zero = (rank_n == '0);

  // Configuration and item capture.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r   <= sgdmf_pkg::LR_RESET;
      rank_r <= sgdmf_pkg::RANK_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        sgdmf_pkg::CFG_LR:   lr_r <= cfg_data;
        sgdmf_pkg::CFG_RANK: rank_r <= cfg_data[4:0];
        default:             lr_r <= lr_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      op_r        <= in_opcode;
      row_r       <= in_row_index;
      col_r       <= in_col_index;
      slot_item_r <= in_rank_slot;
      val_r       <= in_value;
      row_base_r  <= RAW'(int'(in_row_index) * RANK);
      col_base_r  <= CAW'(int'(in_col_index) * RANK);
    end
  end

  // Memory addressing and write port.
  assign rd_slot = cmd.sel_item_slot ? SW'(slot_item_r) : slot;
  assign row_ra  = RAW'(row_base_r + RAW'(rd_slot));
  assign col_ra  = CAW'(col_base_r + CAW'(rd_slot));
  assign row_wa  = cmd.wr_en ? row_ra : RAW'(row_base_r + RAW'(slot2_r));
  assign col_wa  = cmd.wr_en ? col_ra : CAW'(col_base_r + CAW'(slot2_r));
  assign wdata   = cmd.wr_en ? val_r : upd_clip[31:0];
  assign row_we  = (cmd.wr_en && kind == sgdmf_pkg::K_WR_ROW) ||
                   (v2_r && cmd.mode == sgdmf_pkg::M_ROW);
  assign col_we  = (cmd.wr_en && kind == sgdmf_pkg::K_WR_COL) ||
                   (v2_r && cmd.mode == sgdmf_pkg::M_COL);

  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_wa] <= wdata;
    if (cmd.rd_en) rd_row_r <= row_mem[row_ra];
  end

  always_ff @(posedge clk) begin
    if (col_we) col_mem[col_wa] <= wdata;
    if (cmd.rd_en) rd_col_r <= col_mem[col_ra];
  end

  // Shared multiplier stage.
  always_comb begin
    case (cmd.mode)
      sgdmf_pkg::M_STEP: begin
        mul_a = {17'b0, lr_r};
        mul_b = {err_r[31], err_r};
      end
      sgdmf_pkg::M_DOT: begin
        mul_a = {rd_row_r[31], rd_row_r};
        mul_b = {rd_col_r[31], rd_col_r};
      end
      sgdmf_pkg::M_ROW: begin
        mul_a = step_r;
        mul_b = {rd_col_r[31], rd_col_r};
      end
      default: begin
        mul_a = step_r;
        mul_b = {rd_row_r[31], rd_row_r};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    slot1_r <= slot;
    if (v1_r) begin
      prod_r  <= mul_a * mul_b;
      old2_r  <= (cmd.mode == sgdmf_pkg::M_COL) ? rd_col_r : rd_row_r;
      slot2_r <= slot1_r;
    end
  end

  // Accumulate, error, step and factor update.
  assign err_diff = {{24{val_r[31]}}, val_r} - acc_r;
  assign err_clip = sgdmf_pkg::clip_q(err_diff);
  assign upd_sum  = {{24{old2_r[31]}}, old2_r} + {{7{prod_r[64]}}, prod_r[64:16]};
  assign upd_clip = sgdmf_pkg::clip_q(upd_sum);

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (v2_r && cmd.mode == sgdmf_pkg::M_DOT) begin
      acc_r <= acc_r + {{6{prod_r[65]}}, prod_r[65:16]};
    end
    if (cmd.err_load) err_r <= err_clip[31:0];
    if (v2_r && cmd.mode == sgdmf_pkg::M_STEP) step_r <= prod_r[48:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= 1'b0;
    end else if (cmd.in_take) begin
      sat_r <= 1'b0;
    end else if (cmd.err_load) begin
      sat_r <= sat_r | err_clip[32];
    end else if (v2_r && (cmd.mode == sgdmf_pkg::M_ROW || cmd.mode == sgdmf_pkg::M_COL)) begin
      sat_r <= sat_r | upd_clip[32];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.res_sel)
        sgdmf_pkg::R_ROW: begin
          out_res_r <= rd_row_r;
          out_sat_r <= 1'b0;
        end
        sgdmf_pkg::R_COL: begin
          out_res_r <= rd_col_r;
          out_sat_r <= 1'b0;
        end
        sgdmf_pkg::R_ERR: begin
          out_res_r <= err_r;
          out_sat_r <= sat_r;
        end
        default: begin
          out_res_r <= '0;
          out_sat_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_res_r;
  assign out_saturated    = out_sat_r;

endmodule

// File: rtl/sgd_matrix_factorization.sv
// Top level of the SGD matrix factorization engine.
//
//  Channel  Ports                                   Direction  Flow
//  in       in_valid/in_stall, opcode..value        input      valid / stall
//  out      out_valid/out_stall, result, saturated  output     valid / stall
//  cfg      cfg_valid/cfg_ready, cfg_index/data     input      valid / ready
//
// Writes and reads handle one item each. Train and evaluate walk the n active rank slots,
// where n is the active rank, because one shared multiplier pipeline walks the slots in the
// dot pass and both update passes.
// Reset clears control state and restores the configuration defaults; factor memories hold garbage until written.
// Input is stalled while an item is in flight; a stalled result holds the block.
module sgd_matrix_factorization #(
  parameter int ROWS = 64,
  parameter int COLS = 64,
  parameter int RANK = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [5:0]  in_row_index,
  input  logic [5:0]  in_col_index,
  input  logic [3:0]  in_rank_slot,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_value,
  output logic        out_saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SW = (RANK > 1) ? $clog2(RANK) : 1;
  localparam int NW = $clog2(RANK + 1);

  sgdmf_pkg::cmd_t    cmd;
  sgdmf_pkg::status_t stat;
  logic [SW-1:0] slot;
  logic [NW-1:0] rank_n;

  assign cfg_ready = 1'b1;

  sgdmf_ctrl #(.RANK(RANK), .SW(SW), .NW(NW)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .rank_n   (rank_n),
    .cmd      (cmd),
    .slot     (slot)
  );

  sgdmf_dpath #(.ROWS(ROWS), .COLS(COLS), .RANK(RANK), .SW(SW), .NW(NW)) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_opcode        (in_opcode),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_rank_slot     (in_rank_slot),
    .in_value         (in_value),
    .cfg_valid        (cfg_valid & cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_saturated    (out_saturated),
    .cmd              (cmd),
    .slot             (slot),
    .stat             (stat),
    .rank_n           (rank_n)
  );

endmodule

// File: bench/tb_sgd_matrix_factorization.sv
// Self-checking testbench for the SGD matrix factorization engine with a built-in predictor.
`timescale 1ns / 100ps

module tb_sgd_matrix_factorization;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam int N_ROWS = 64;
  localparam int N_COLS = 64;
  localparam int N_SLOTS = 16;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [2:0]  op;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [3:0]  slot;
    logic [31:0] val;
  } sample_t;

  typedef struct {
    logic [31:0] value;
    logic        sat;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_opcode = '0;
  logic [5:0]  in_row_index = '0;
  logic [5:0]  in_col_index = '0;
  logic [3:0]  in_rank_slot = '0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [31:0] out_result_value;
  logic        out_saturated;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = sgdmf_pkg::CFG_LR;
  logic [15:0] cfg_data = '0;

  sgd_matrix_factorization u_top (.*);

  always #2 clk = ~clk;

  sample_t pending_q[$];
  answer_t answer_q[$];
  sample_t cur;
  bit      took;
  int      cycles;
  int      errors;
  int      n_train;
  int      n_eval;
  int      n_sat;
  int      n_checked;

  logic signed [31:0] row_model[N_ROWS][N_SLOTS];
  logic signed [31:0] col_model[N_COLS][N_SLOTS];
  logic [15:0] model_rate = sgdmf_pkg::LR_RESET;
  logic [4:0]  model_rank = sgdmf_pkg::RANK_RESET;
  bit row_known[N_ROWS][N_SLOTS];
  bit col_known[N_COLS][N_SLOTS];

  logic [15:0] rates[7] = '{16'd655, 16'd65535, 16'd0, 16'd1000, 16'd30000, 16'd65535, 16'd1};
  logic [4:0]  ranks[7] = '{5'd16, 5'd16, 5'd1, 5'd8, 5'd31, 5'd0, 5'd16};

  function automatic logic [31:0] clip_word(input longint x, inout logic flag);
    if (x > 64'sd2147483647) begin
      flag = 1'b1;
      return 32'h7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      flag = 1'b1;
      return 32'h8000_0000;
    end
    return x[31:0];
  endfunction

  function automatic answer_t factorize_step(input sample_t s);
    answer_t a;
    longint acc;
    longint step;
    int n;
    a.value = '0;
    a.sat = 1'b0;
    n = (model_rank > N_SLOTS) ? N_SLOTS : int'(model_rank);
    case (s.op)
      sgdmf_pkg::OP_WR_ROW: row_model[s.row][s.slot] = s.val;
      sgdmf_pkg::OP_WR_COL: col_model[s.col][s.slot] = s.val;
      sgdmf_pkg::OP_RD_ROW: a.value = row_model[s.row][s.slot];
      sgdmf_pkg::OP_RD_COL: a.value = col_model[s.col][s.slot];
      sgdmf_pkg::OP_TRAIN, sgdmf_pkg::OP_EVAL: begin
        acc = 0;
        for (int i = 0; i < n; i++) begin
          acc += (longint'(row_model[s.row][i]) * longint'(col_model[s.col][i])) >>> 16;
        end
        a.value = clip_word(longint'($signed(s.val)) - acc, a.sat);
        if (s.op == sgdmf_pkg::OP_TRAIN) begin
          step = (longint'(model_rate) * longint'($signed(a.value))) >>> 16;
          for (int i = 0; i < n; i++) begin
            row_model[s.row][i] = clip_word(longint'(row_model[s.row][i])
                + ((step * longint'(col_model[s.col][i])) >>> 16), a.sat);
          end
          for (int i = 0; i < n; i++) begin
            col_model[s.col][i] = clip_word(longint'(col_model[s.col][i])
                + ((step * longint'(row_model[s.row][i])) >>> 16), a.sat);
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic logic [31:0] pick_value(input bit factor);
    int r;
    r = $urandom_range(99);
    if (r < 6) return 32'h7FFF_FFFF;
    if (r < 12) return 32'h8000_0000;
    if (r < 22) return $urandom;
    if (factor) return 32'($signed($urandom_range(196608)) - 98304);
    return 32'($signed($urandom_range(1048576)) - 524288);
  endfunction

  function automatic logic [5:0] pool_index();
    int k;
    k = $urandom_range(7);
    return (k < 4) ? 6'(k) : 6'(56 + k);
  endfunction

  function automatic void queue_item(input logic [2:0] op, input logic [5:0] row,
                                     input logic [5:0] col, input logic [3:0] slot,
                                     input logic [31:0] val);
    sample_t s;
    s.op = op;
    s.row = row;
    s.col = col;
    s.slot = slot;
    s.val = val;
    if (op == sgdmf_pkg::OP_WR_ROW) row_known[row][slot] = 1'b1;
    if (op == sgdmf_pkg::OP_WR_COL) col_known[col][slot] = 1'b1;
    pending_q.push_back(s);
  endfunction

  function automatic void queue_random();
    int r;
    logic [5:0] row;
    logic [5:0] col;
    logic [3:0] slot;
    r = $urandom_range(99);
    row = 6'($urandom);
    col = 6'($urandom);
    slot = 4'($urandom);
    if (r < 35) begin
      queue_item(sgdmf_pkg::OP_TRAIN, pool_index(), pool_index(), slot, pick_value(1'b0));
    end else if (r < 55) begin
      queue_item(sgdmf_pkg::OP_EVAL, pool_index(), pool_index(), slot, pick_value(1'b0));
    end else if (r < 63) begin
      queue_item(sgdmf_pkg::OP_WR_ROW, row, col, slot, pick_value(1'b1));
    end else if (r < 71) begin
      queue_item(sgdmf_pkg::OP_WR_COL, row, col, slot, pick_value(1'b1));
    end else if (r < 81) begin
      if (!row_known[row][slot]) row = pool_index();
      queue_item(sgdmf_pkg::OP_RD_ROW, row, col, slot, $urandom);
    end else if (r < 91) begin
      if (!col_known[col][slot]) col = pool_index();
      queue_item(sgdmf_pkg::OP_RD_COL, row, col, slot, $urandom);
    end else begin
      queue_item((r < 96) ? OP_SPARE_A : OP_SPARE_B, row, col, slot, $urandom);
    end
  endfunction

  function automatic bit idle_now();
    if ((cycles / 5000) % 4 == 2) return 1'b0;
    return $urandom_range(99) < 36;
  endfunction

  task automatic wait_quiet();
    do @(posedge clk);
    while (pending_q.size() != 0 || answer_q.size() != 0 || in_valid);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == sgdmf_pkg::CFG_LR) model_rate = data;
    else model_rank = data[4:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drive one input beat per handshake; new beats appear only at the falling edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      answer_q.push_back(factorize_step(cur));
      if (cur.op == sgdmf_pkg::OP_TRAIN) n_train++;
      if (cur.op == sgdmf_pkg::OP_EVAL) n_eval++;
      took = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      out_stall <= idle_now();
      if (!in_valid || took) begin
        took = 1'b0;
        if (pending_q.size() != 0 && !idle_now()) begin
          cur = pending_q.pop_front();
          in_valid <= 1'b1;
          in_opcode <= cur.op;
          in_row_index <= cur.row;
          in_col_index <= cur.col;
          in_rank_slot <= cur.slot;
          in_value <= cur.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (answer_q.size() == 0) begin
        $error("unexpected result beat: result_value %h saturated %b",
               out_result_value, out_saturated);
        errors++;
      end else begin
        want = answer_q.pop_front();
        n_checked++;
        if (out_saturated) n_sat++;
        if (out_result_value !== want.value) begin
          $error("result_value mismatch: expected %h actual %h", want.value,
                 out_result_value);
          errors++;
        end
        if (out_saturated !== want.sat) begin
          $error("saturated mismatch: expected %b actual %b", want.sat, out_saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    for (int r = 0; r < N_ROWS; r++) begin
      for (int k = 0; k < N_SLOTS; k++) begin
        row_model[r][k] = '0;
        col_model[r][k] = '0;
        row_known[r][k] = 1'b0;
        col_known[r][k] = 1'b0;
      end
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Extremes first: opposite full-scale factors push the error past the word range.
    queue_item(sgdmf_pkg::OP_WR_ROW, 6'd0, 6'd63, 4'd0, 32'h8000_0000);
    queue_item(sgdmf_pkg::OP_WR_COL, 6'd63, 6'd0, 4'd0, 32'h7FFF_FFFF);
    queue_item(sgdmf_pkg::OP_WR_ROW, 6'd63, 6'd0, 4'd15, 32'h7FFF_FFFF);
    queue_item(sgdmf_pkg::OP_WR_COL, 6'd0, 6'd63, 4'd15, 32'h8000_0000);
    queue_item(sgdmf_pkg::OP_RD_ROW, 6'd0, 6'd0, 4'd0, 32'hFFFF_FFFF);
    queue_item(sgdmf_pkg::OP_RD_COL, 6'd0, 6'd0, 4'd0, 32'h0);
    queue_item(sgdmf_pkg::OP_RD_ROW, 6'd63, 6'd0, 4'd15, 32'h0);
    queue_item(sgdmf_pkg::OP_RD_COL, 6'd0, 6'd63, 4'd15, 32'h0);
    queue_item(OP_SPARE_A, 6'd63, 6'd63, 4'd15, 32'hFFFF_FFFF);
    queue_item(OP_SPARE_B, 6'd0, 6'd0, 4'd0, 32'h0);
    for (int r = 0; r < 8; r++) begin
      for (int k = 0; k < N_SLOTS; k++) begin
        queue_item(sgdmf_pkg::OP_WR_ROW, (r < 4) ? 6'(r) : 6'(56 + r), 6'($urandom), 4'(k),
                   (k == 0 && r == 0) ? 32'h8000_0000 : pick_value(1'b1));
        queue_item(sgdmf_pkg::OP_WR_COL, 6'($urandom), (r < 4) ? 6'(r) : 6'(56 + r), 4'(k),
                   (k == 0 && r == 0) ? 32'h7FFF_FFFF : pick_value(1'b1));
      end
    end
    queue_item(sgdmf_pkg::OP_EVAL, 6'd0, 6'd0, 4'd0, 32'h7FFF_FFFF);
    queue_item(sgdmf_pkg::OP_EVAL, 6'd63, 6'd63, 4'd15, 32'h8000_0000);
    queue_item(sgdmf_pkg::OP_TRAIN, 6'd0, 6'd0, 4'd0, 32'h7FFF_FFFF);
    queue_item(sgdmf_pkg::OP_TRAIN, 6'd63, 6'd63, 4'd15, 32'h0);
    queue_item(sgdmf_pkg::OP_RD_ROW, 6'd0, 6'd0, 4'd3, 32'h0);

    for (int p = 0; p < 7; p++) begin
      wait_quiet();
      write_reg(sgdmf_pkg::CFG_LR, rates[p]);
      write_reg(sgdmf_pkg::CFG_RANK, {11'd0, ranks[p]});
      for (int i = 0; i < 200; i++) queue_random();
    end
    wait_quiet();

    $display("Checked %0d results: %0d train and %0d evaluate samples, %0d saturated,",
             n_checked, n_train, n_eval, n_sat);
    $display("across seven rate and rank settings including the extremes.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/sgdmf_pkg.sv
rtl/sgdmf_ctrl.sv
rtl/sgdmf_dpath.sv
rtl/sgd_matrix_factorization.sv
bench/tb_sgd_matrix_factorization.sv
